### sv/spa_pkg.sv
// shared types and constants of the slot pool allocator
`timescale 1ns / 1ps

package spa_pkg;

  // fixed field widths
  localparam int unsigned OpW       = 2;
  localparam int unsigned SlotIdxW  = 10;
  localparam int unsigned BinW      = 16;
  localparam int unsigned StatusW   = 2;
  localparam int unsigned CfgW      = 11;

  // default pool depth and reset value of the slot limit
  localparam int unsigned MaxSlotsDef = 1024;
  localparam logic [CfgW-1:0] SlotsInUseRst = 11'd1024;

  // operation codes
  typedef enum logic [OpW-1:0] {
    OpAlloc = 2'd0,
    OpFree  = 2'd1,
    OpRead  = 2'd2,
    OpClear = 2'd3
  } op_e;

  // result status codes
  typedef enum logic [StatusW-1:0] {
    StOk       = 2'd0,
    StFull     = 2'd1,
    StNotAlloc = 2'd2
  } status_e;

  // controller to datapath commands
  typedef struct packed {
    logic load;    // capture transaction and read the stores
    logic commit;  // execute the held transaction and load the result register
  } cmd_t;

endpackage

### sv/spa_if.sv
// request and response channel interfaces of the slot pool allocator
`timescale 1ns / 1ps

interface spa_req_if;
  logic                         valid;
  logic                         ready;
  logic [spa_pkg::OpW-1:0]      opcode;
  logic [spa_pkg::SlotIdxW-1:0] slot_index;
  logic [spa_pkg::BinW-1:0]     bin_tag;

  modport source (output valid, opcode, slot_index, bin_tag, input ready);
  modport sink   (input valid, opcode, slot_index, bin_tag, output ready);
endinterface

interface spa_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [spa_pkg::SlotIdxW-1:0] result_slot;
  logic [spa_pkg::BinW-1:0]     result_bin;
  logic [spa_pkg::StatusW-1:0]  status;

  modport source (output valid, result_slot, result_bin, status, input ready);
  modport sink   (input valid, result_slot, result_bin, status, output ready);
endinterface

### sv/spa_ctrl.sv
// control state machine: transaction sequencing and result register handshake
`timescale 1ns / 1ps

module spa_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output spa_pkg::cmd_t cmd_o
);
  import spa_pkg::*;

  typedef enum logic {
    StIdle,
    StExec
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   commit;

  // accept in idle, execute once the result register has room
  assign in_ready_o  = (state_q == StIdle);
  assign commit      = (state_q == StExec) && (!out_valid_q || out_ready_i);
  assign cmd_o.load   = in_valid_i && in_ready_o;
  assign cmd_o.commit = commit;
  assign out_valid_o  = out_valid_q;

  // state and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            state_q <= StExec;
          end
        end
        StExec: begin
          if (commit) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

### sv/spa_dp.sv
// datapath: free list, bump counter, slot stores and result register
`timescale 1ns / 1ps

module spa_dp #(
  parameter int unsigned MAX_SLOTS = spa_pkg::MaxSlotsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  spa_pkg::cmd_t                cmd_i,
  input  logic [spa_pkg::OpW-1:0]      opcode_i,
  input  logic [spa_pkg::SlotIdxW-1:0] slot_index_i,
  input  logic [spa_pkg::BinW-1:0]     bin_tag_i,
  input  logic                         cfg_we_i,
  input  logic [spa_pkg::CfgW-1:0]     cfg_wdata_i,
  output logic [spa_pkg::SlotIdxW-1:0] result_slot_o,
  output logic [spa_pkg::BinW-1:0]     result_bin_o,
  output logic [spa_pkg::StatusW-1:0]  status_o
);
  import spa_pkg::*;

  localparam int unsigned SlotW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int unsigned CntW  = $clog2(MAX_SLOTS + 1);

  // stores: link carries a null flag on top, mark is only trusted below the bump count
  logic [SlotW:0]    link_mem [MAX_SLOTS];
  logic              mark_mem [MAX_SLOTS];
  logic [BinW-1:0]   bin_mem  [MAX_SLOTS];

  // control state
  logic [SlotW:0]    head_q, head_d;
  logic [CntW-1:0]   bump_q, bump_d;
  logic [CfgW-1:0]   slots_q;

  // held transaction and read data
  op_e               op_q;
  logic [SlotIdxW-1:0] idx_q;
  logic [BinW-1:0]   tag_q;
  logic [SlotW:0]    link_rd_q;
  logic              mark_rd_q;
  logic [BinW-1:0]   bin_rd_q;

  // result register
  logic [SlotIdxW-1:0] res_slot_q, res_slot_d;
  logic [BinW-1:0]   res_bin_q, res_bin_d;
  status_e           res_st_q, res_st_d;

  // write ports
  logic              link_we, mark_we, mark_wd, bin_we;
  logic [SlotW-1:0]  link_wa, mark_wa, bin_wa;

  logic [CntW-1:0]   limit;
  logic [SlotW-1:0]  idx_addr, rd_idx_addr, alloc_slot;
  logic              idx_alloc;

  assign rd_idx_addr = SlotW'(slot_index_i);
  assign idx_addr    = SlotW'(idx_q);
  assign limit = (32'(slots_q) < 32'(MAX_SLOTS)) ? CntW'(slots_q) : CntW'(MAX_SLOTS);
  // slot is allocated only if in range, already handed out since clear, and marked
  assign idx_alloc = (32'(idx_q) < 32'(MAX_SLOTS)) && (32'(idx_q) < 32'(bump_q)) && mark_rd_q;

  // execute the held transaction
  always_comb begin
    head_d     = head_q;
    bump_d     = bump_q;
    res_slot_d = '0;
    res_bin_d  = '0;
    res_st_d   = StOk;
    link_we    = 1'b0;
    link_wa    = idx_addr;
    mark_we    = 1'b0;
    mark_wa    = idx_addr;
    mark_wd    = 1'b0;
    bin_we     = 1'b0;
    bin_wa     = idx_addr;
    alloc_slot = head_q[SlotW-1:0];
    case (op_q)
      OpAlloc: begin
        if (!head_q[SlotW]) begin
          alloc_slot = head_q[SlotW-1:0];
          head_d     = link_rd_q;
          mark_we    = 1'b1;
          bin_we     = 1'b1;
        end else if (bump_q < limit) begin
          alloc_slot = SlotW'(bump_q);
          bump_d     = bump_q + CntW'(1);
          mark_we    = 1'b1;
          bin_we     = 1'b1;
        end else begin
          res_st_d   = StFull;
        end
        mark_wa = alloc_slot;
        mark_wd = 1'b1;
        bin_wa  = alloc_slot;
        if (mark_we) begin
          res_slot_d = SlotIdxW'(alloc_slot);
        end
      end
      OpFree: begin
        if (idx_alloc) begin
          mark_we = 1'b1;
          link_we = 1'b1;
          head_d  = {1'b0, idx_addr};
        end else begin
          res_st_d = StNotAlloc;
        end
      end
      OpRead: begin
        if (idx_alloc) begin
          res_bin_d = bin_rd_q;
        end
      end
      default: begin
        head_d = {1'b1, {SlotW{1'b0}}};
        bump_d = '0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= {1'b1, {SlotW{1'b0}}};
      bump_q  <= '0;
      slots_q <= SlotsInUseRst;
    end else begin
      if (cmd_i.commit) begin
        head_q <= head_d;
        bump_q <= bump_d;
      end
      if (cfg_we_i) begin
        slots_q <= cfg_wdata_i;
      end
    end
  end

  // transaction capture, result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= op_e'(opcode_i);
      idx_q <= slot_index_i;
      tag_q <= bin_tag_i;
    end
    if (cmd_i.commit) begin
      res_slot_q <= res_slot_d;
      res_bin_q  <= res_bin_d;
      res_st_q   <= res_st_d;
    end
  end

  // link store
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && link_we) begin
      link_mem[link_wa] <= head_q;
    end
    if (cmd_i.load) begin
      link_rd_q <= link_mem[head_q[SlotW-1:0]];
    end
  end

  // allocated mark store
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && mark_we) begin
      mark_mem[mark_wa] <= mark_wd;
    end
    if (cmd_i.load) begin
      mark_rd_q <= mark_mem[rd_idx_addr];
    end
  end

  // bin tag store
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && bin_we) begin
      bin_mem[bin_wa] <= tag_q;
    end
    if (cmd_i.load) begin
      bin_rd_q <= bin_mem[rd_idx_addr];
    end
  end

  assign result_slot_o = res_slot_q;
  assign result_bin_o  = res_bin_q;
  assign status_o      = res_st_q;

endmodule

### sv/slot_pool_allocator.sv
// top level of the slot pool allocator
`timescale 1ns / 1ps

// Fixed-slot buffer manager. Each request transaction is allocate, free, read tag
// or clear, and gives exactly one response transaction. Allocate pops the free
// list head, else hands out the next never-used slot up to the configured limit,
// else reports pool full. Free of a slot that is not allocated reports an error.
// Each transaction has a read step of the link, mark and tag stores (synchronous
// single-port memories) and an execute step that updates the free list and loads
// the result register; the next allocate needs the popped link from that read. A
// result waiting in the output register holds the execute step until taken. There
// is no clearing pass after reset or clear: slot marks are only trusted below the
// bump count, which clear returns to zero. The user must write the slot limit
// register only while no transaction is outstanding; the block does not check it.
module slot_pool_allocator #(
  parameter int unsigned MAX_SLOTS = spa_pkg::MaxSlotsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  spa_req_if.sink                  req_i,
  spa_rsp_if.source                rsp_o,
  input  logic                     cfg_we_i,
  input  logic [spa_pkg::CfgW-1:0] cfg_wdata_i
);
  import spa_pkg::*;

  cmd_t cmd;

  // sequencing
  spa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .cmd_o       (cmd)
  );

  // stores and result
  spa_dp #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .opcode_i      (req_i.opcode),
    .slot_index_i  (req_i.slot_index),
    .bin_tag_i     (req_i.bin_tag),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .result_slot_o (rsp_o.result_slot),
    .result_bin_o  (rsp_o.result_bin),
    .status_o      (rsp_o.status)
  );

endmodule
